### design/itp_pkg.sv
// ----------------------------------------------------------------------------
// itp_pkg
// Shared types, character codes and helper functions for the infix to
// postfix converter.
// ----------------------------------------------------------------------------
package itp_pkg;

  // Operator stack depth and derived widths
  localparam int STACK_DEPTH = 32;
  localparam int CNT_W       = $clog2(STACK_DEPTH + 1);
  localparam int IDX_W       = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;

  // Characters with a role of their own
  localparam logic [7:0] CH_LPAREN = 8'h28;
  localparam logic [7:0] CH_RPAREN = 8'h29;
  localparam logic [7:0] CH_PLUS   = 8'h2B;
  localparam logic [7:0] CH_MINUS  = 8'h2D;
  localparam logic [7:0] CH_STAR   = 8'h2A;
  localparam logic [7:0] CH_SLASH  = 8'h2F;
  localparam logic [7:0] CH_CARET  = 8'h5E;
  localparam logic [7:0] CH_LOW_A  = 8'h61;
  localparam logic [7:0] CH_LOW_Z  = 8'h7A;
  localparam logic [7:0] CASE_BIT  = 8'h20;

  typedef enum logic [1:0] {
    ERR_NONE      = 2'd0,
    ERR_FULL      = 2'd1,
    ERR_UNMATCHED = 2'd2
  } err_t;

  // Input word
  typedef struct packed {
    logic [7:0] in_char;
    logic       in_last;
  } in_word_t;

  // Output word
  typedef struct packed {
    logic [7:0] out_char;
    logic       has_char;
    logic       out_last;
    logic [1:0] error_code;
  } out_word_t;

  // Operator precedence: '(' 0, +- 1, */ 2, ^ 3, anything else 4
  function automatic logic [2:0] prec_of(input logic [7:0] c);
    logic [2:0] p;
    p = 3'd4;
    if (c == CH_LPAREN) p = 3'd0;
    else if (c == CH_PLUS || c == CH_MINUS) p = 3'd1;
    else if (c == CH_STAR || c == CH_SLASH) p = 3'd2;
    else if (c == CH_CARET) p = 3'd3;
    return p;
  endfunction

  // A-Z or a-z
  function automatic logic is_letter(input logic [7:0] c);
    logic [7:0] l;
    l = c | CASE_BIT;
    return (l >= CH_LOW_A) && (l <= CH_LOW_Z);
  endfunction

endpackage

### design/itp_in_if.sv
// ----------------------------------------------------------------------------
// itp_in_if
// Valid/ready channel carrying infix input words.
// ----------------------------------------------------------------------------
interface itp_in_if;
  logic             valid;
  logic             ready;
  itp_pkg::in_word_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

### design/itp_out_if.sv
// ----------------------------------------------------------------------------
// itp_out_if
// Valid/ready channel carrying postfix output words.
// ----------------------------------------------------------------------------
interface itp_out_if;
  logic              valid;
  logic              ready;
  itp_pkg::out_word_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

### design/infix_to_postfix_converter.sv
// ----------------------------------------------------------------------------
// infix_to_postfix_converter
// Shunting-yard converter: one infix character in, postfix characters out.
// ----------------------------------------------------------------------------
// One character is taken per input word and the block then stays busy until
// that character is fully handled. A word passes through accept, decide and
// release; while deciding, each character popped off the stack is sent out
// in turn, and a ')' that meets its '(' discards it as the decision ends. The
// word marked last then has its stack flushed character by character, and the
// flush closes before release. Output back-pressure holds any of these steps.
// The pace is set by the single operator stack, which is read or written
// once per cycle under the sequencer. Each result is held one step in a
// staging register so that the final one can be marked last; a word that
// yields nothing on the last character gives a marker with has_char low.
// A push onto a full stack is dropped and reported as error 1, a ')' with no
// matching '(' as error 2. No clearing pass is needed after reset.
// ----------------------------------------------------------------------------
module infix_to_postfix_converter (
  input  logic clk,
  input  logic rst,
  itp_in_if.sink    in_word,
  itp_out_if.source out_word
);

  typedef enum logic [3:0] {
    S_IDLE  = 4'b0001,
    S_WORK  = 4'b0010,
    S_FLUSH = 4'b0100,
    S_DONE  = 4'b1000
  } state_t;

  state_t                       state, state_next;
  logic [7:0]                   cur_char;
  logic                         cur_last;
  logic [itp_pkg::CNT_W-1:0]    count;
  logic [7:0]                   stack [itp_pkg::STACK_DEPTH];
  logic [7:0]                   top;
  logic                         pend_valid;
  itp_pkg::out_word_t           pend;
  logic                         obuf_valid;
  itp_pkg::out_word_t           obuf;

  logic                         obuf_free, slot_ok, not_full;
  logic [itp_pkg::IDX_W-1:0]    below_idx;
  logic                         gen_valid, do_push, do_pop, load_obuf, pend_clear;
  itp_pkg::out_word_t           gen, obuf_in;
  state_t                       after_work;

  assign in_word.ready  = (state == S_IDLE);
  assign out_word.valid = obuf_valid;
  assign out_word.data  = obuf;

  assign obuf_free  = !obuf_valid || out_word.ready;
  assign slot_ok    = !pend_valid || obuf_free;
  assign not_full   = count < itp_pkg::CNT_W'(itp_pkg::STACK_DEPTH);
  assign below_idx  = itp_pkg::IDX_W'(count - itp_pkg::CNT_W'(2));
  assign after_work = cur_last ? S_FLUSH : S_DONE;

  // Sequencer: one stack action and at most one result per cycle
  always_comb begin
    state_next = state;
    gen_valid  = 1'b0;
    gen        = '0;
    do_push    = 1'b0;
    do_pop     = 1'b0;
    load_obuf  = 1'b0;
    pend_clear = 1'b0;
    obuf_in    = pend;
    case (state)
      S_IDLE: begin
        if (in_word.valid) state_next = S_WORK;
      end
      S_WORK: begin
        if (itp_pkg::is_letter(cur_char)) begin
          if (slot_ok) begin
            gen_valid    = 1'b1;
            gen.out_char = cur_char;
            gen.has_char = 1'b1;
            state_next   = after_work;
          end
        end else if (cur_char == itp_pkg::CH_LPAREN) begin
          if (not_full) begin
            do_push    = 1'b1;
            state_next = after_work;
          end else if (slot_ok) begin
            gen_valid      = 1'b1;
            gen.error_code = itp_pkg::ERR_FULL;
            state_next     = after_work;
          end
        end else if (cur_char == itp_pkg::CH_RPAREN) begin
          if (count == '0) begin
            if (slot_ok) begin
              gen_valid      = 1'b1;
              gen.error_code = itp_pkg::ERR_UNMATCHED;
              state_next     = after_work;
            end
          end else if (top == itp_pkg::CH_LPAREN) begin
            do_pop     = 1'b1;
            state_next = after_work;
          end else if (slot_ok) begin
            do_pop       = 1'b1;
            gen_valid    = 1'b1;
            gen.out_char = top;
            gen.has_char = 1'b1;
          end
        end else begin
          // operator: pop while its precedence does not exceed the top's
          if (count != '0 &&
              itp_pkg::prec_of(cur_char) <= itp_pkg::prec_of(top)) begin
            if (slot_ok) begin
              do_pop       = 1'b1;
              gen_valid    = 1'b1;
              gen.out_char = top;
              gen.has_char = 1'b1;
            end
          end else if (not_full) begin
            do_push    = 1'b1;
            state_next = after_work;
          end else if (slot_ok) begin
            gen_valid      = 1'b1;
            gen.error_code = itp_pkg::ERR_FULL;
            state_next     = after_work;
          end
        end
      end
      S_FLUSH: begin
        if (count != '0) begin
          if (slot_ok) begin
            do_pop       = 1'b1;
            gen_valid    = 1'b1;
            gen.out_char = top;
            gen.has_char = 1'b1;
          end
        end else begin
          state_next = S_DONE;
        end
      end
      S_DONE: begin
        // release the staged result, marking it last where it ends the expression
        if (pend_valid) begin
          if (obuf_free) begin
            load_obuf        = 1'b1;
            pend_clear       = 1'b1;
            obuf_in.out_last = cur_last;
            state_next       = S_IDLE;
          end
        end else if (cur_last) begin
          if (obuf_free) begin
            load_obuf        = 1'b1;
            obuf_in          = '0;
            obuf_in.out_last = 1'b1;
            state_next       = S_IDLE;
          end
        end else begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
    // a new result pushes the staged one out
    if (gen_valid && pend_valid) load_obuf = 1'b1;
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      count      <= '0;
      pend_valid <= 1'b0;
      obuf_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (do_push) count <= count + itp_pkg::CNT_W'(1);
      else if (do_pop) count <= count - itp_pkg::CNT_W'(1);
      if (gen_valid) pend_valid <= 1'b1;
      else if (pend_clear) pend_valid <= 1'b0;
      if (load_obuf) obuf_valid <= 1'b1;
      else if (out_word.ready) obuf_valid <= 1'b0;
    end
  end

  // Payload registers and operator stack
  always_ff @(posedge clk) begin
    if (state == S_IDLE && in_word.valid) begin
      cur_char <= in_word.data.in_char;
      cur_last <= in_word.data.in_last;
    end
    if (do_push) stack[count[itp_pkg::IDX_W-1:0]] <= cur_char;
    // top of stack held in a register; a pop reloads it from the entry beneath
    if (do_push) top <= cur_char;
    else if (do_pop && count > itp_pkg::CNT_W'(1)) top <= stack[below_idx];
    if (gen_valid) pend <= gen;
    if (load_obuf) obuf <= obuf_in;
  end

endmodule

### bench/itp_tb_pkg.sv
// ----------------------------------------------------------------------------
// itp_tb_pkg
// Scoreboard for the infix to postfix converter bench. It keeps its own
// operator stack, works out the postfix words due for each accepted infix
// word and checks the words that come out of the block in order.
// ----------------------------------------------------------------------------
package itp_tb_pkg;

  // Upper or lower case letter
  function automatic bit alpha_char(input logic [7:0] c);
    logic [7:0] folded;
    folded = c | itp_pkg::CASE_BIT;
    return (folded >= itp_pkg::CH_LOW_A) && (folded <= itp_pkg::CH_LOW_Z);
  endfunction

  class postfix_scoreboard;
    logic [7:0]          op_stack [itp_pkg::STACK_DEPTH];
    int unsigned         stack_used;
    itp_pkg::out_word_t  step_words[$];
    itp_pkg::out_word_t  postfix_due[$];
    int unsigned         mismatches;

    function new();
      stack_used = 0;
      mismatches = 0;
    endfunction

    // Binding strength: '(' weakest, then +-, */, ^, any other byte strongest
    function int unsigned binding(input logic [7:0] c);
      if (c == itp_pkg::CH_LPAREN) return 0;
      if (c == itp_pkg::CH_PLUS || c == itp_pkg::CH_MINUS) return 1;
      if (c == itp_pkg::CH_STAR || c == itp_pkg::CH_SLASH) return 2;
      if (c == itp_pkg::CH_CARET) return 3;
      return 4;
    endfunction

    function void emit(input logic [7:0] ch, input logic has, input logic [1:0] err);
      itp_pkg::out_word_t w;
      w.out_char   = ch;
      w.has_char   = has;
      w.out_last   = 1'b0;
      w.error_code = err;
      step_words.push_back(w);
    endfunction

    // A push onto a full stack is dropped and flagged
    function void push_op(input logic [7:0] c);
      if (stack_used >= itp_pkg::STACK_DEPTH) begin
        emit(8'h00, 1'b0, itp_pkg::ERR_FULL);
      end else begin
        op_stack[stack_used] = c;
        stack_used++;
      end
    endfunction

    function logic [7:0] pop_op();
      stack_used--;
      return op_stack[stack_used];
    endfunction

    // Work out the postfix words caused by one accepted infix word
    function void note_char(input itp_pkg::in_word_t w);
      logic [7:0] c;
      logic [7:0] t;
      bit         found;
      c = w.in_char;
      step_words.delete();
      if (alpha_char(c)) begin
        emit(c, 1'b1, itp_pkg::ERR_NONE);
      end else if (c == itp_pkg::CH_LPAREN) begin
        push_op(c);
      end else if (c == itp_pkg::CH_RPAREN) begin
        found = 1'b0;
        while (stack_used > 0 && !found) begin
          t = pop_op();
          if (t == itp_pkg::CH_LPAREN) found = 1'b1;
          else emit(t, 1'b1, itp_pkg::ERR_NONE);
        end
        if (!found) emit(8'h00, 1'b0, itp_pkg::ERR_UNMATCHED);
      end else begin
        while (stack_used > 0 && binding(c) <= binding(op_stack[stack_used-1]))
          emit(pop_op(), 1'b1, itp_pkg::ERR_NONE);
        push_op(c);
      end
      // last word: flush the stack, mark the final word
      if (w.in_last) begin
        while (stack_used > 0) emit(pop_op(), 1'b1, itp_pkg::ERR_NONE);
        if (step_words.size() == 0) emit(8'h00, 1'b0, itp_pkg::ERR_NONE);
        step_words[step_words.size()-1].out_last = 1'b1;
      end
      foreach (step_words[i]) postfix_due.push_back(step_words[i]);
    endfunction

    function void report(input string msg);
      mismatches++;
      if (mismatches <= 10) $display("%s", msg);
    endfunction

    function void check_word(input itp_pkg::out_word_t got);
      itp_pkg::out_word_t want;
      if (postfix_due.size() == 0) begin
        report($sformatf("unexpected word: char %h has %b last %b err %0d",
                         got.out_char, got.has_char, got.out_last, got.error_code));
        return;
      end
      want = postfix_due.pop_front();
      if (got.out_char !== want.out_char || got.has_char !== want.has_char ||
          got.out_last !== want.out_last || got.error_code !== want.error_code)
        report($sformatf({"word mismatch: expected char %h has %b last %b err %0d,",
                          " got char %h has %b last %b err %0d"},
                         want.out_char, want.has_char, want.out_last, want.error_code,
                         got.out_char, got.has_char, got.out_last, got.error_code));
    endfunction

    function int unsigned pending();
      return postfix_due.size();
    endfunction
  endclass

endpackage

### bench/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Bench for the infix to postfix converter. Directed expressions cover every
// operator, letter extremes, odd bytes, unmatched and empty cases; random
// expressions, deep nesting up to stack overflow, broken and noise words
// follow, under four phases of sender gaps and receiver stalls.
// ----------------------------------------------------------------------------
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int SETTLE_CYCLES  = 2 * itp_pkg::STACK_DEPTH + 16;
  localparam int WATCHDOG_LIMIT = 5000;
  localparam int PHASE_WORDS    = 72;

  logic clk;
  logic rst;

  itp_in_if  in_if ();
  itp_out_if out_if ();

  infix_to_postfix_converter i_dut (
    .clk      (clk),
    .rst      (rst),
    .in_word  (in_if),
    .out_word (out_if)
  );

  itp_tb_pkg::postfix_scoreboard sb;
  int unsigned       words_sent;
  int unsigned       idle_pct;
  int unsigned       stall_pct;
  int unsigned       quiet_cycles;
  logic [7:0]        infix_text[$];

  // Clock
  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Output side: random stalls, check each accepted word
  always @(posedge clk) begin
    if (!rst && out_if.valid === 1'b1 && out_if.ready === 1'b1)
      sb.check_word(out_if.data);
    out_if.ready <= ($urandom_range(99) >= stall_pct);
  end

  // Watchdog on cycles with no word moving on either side
  always @(posedge clk) begin
    if (rst || (in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("simulation failed");
        $finish;
      end
    end
  end

  // Send one infix word, with random gaps ahead of it
  task automatic send_char(input logic [7:0] c, input logic last);
    itp_pkg::in_word_t w;
    w.in_char = c;
    w.in_last = last;
    while (idle_pct != 0 && $urandom_range(99) < idle_pct) begin
      in_if.valid <= 1'b0;
      @(posedge clk);
    end
    in_if.valid <= 1'b1;
    in_if.data  <= w;
    do @(posedge clk); while (in_if.ready !== 1'b1);
    sb.note_char(w);
    words_sent++;
  endtask

  // Send the buffered expression, last flag on its final character
  task automatic send_text();
    foreach (infix_text[i]) send_char(infix_text[i], i == infix_text.size() - 1);
  endtask

  task automatic send_string(input string s);
    infix_text.delete();
    for (int i = 0; i < s.len(); i++) infix_text.push_back(s[i]);
    send_text();
  endtask

  // Hold off until every due word has come out, then let the block settle
  task automatic drain();
    in_if.valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  function automatic logic [7:0] rand_letter();
    logic [7:0] lower;
    lower = itp_pkg::CH_LOW_A + 8'($urandom_range(25));
    return $urandom_range(1) ? lower : (lower & ~itp_pkg::CASE_BIT);
  endfunction

  // Mostly the five operators, sometimes a random byte that is neither a letter nor a bracket
  function automatic logic [7:0] rand_op();
    logic [7:0] b;
    case ($urandom_range(11))
      0, 1:    return itp_pkg::CH_PLUS;
      2, 3:    return itp_pkg::CH_MINUS;
      4, 5:    return itp_pkg::CH_STAR;
      6, 7:    return itp_pkg::CH_SLASH;
      8, 9:    return itp_pkg::CH_CARET;
      default: begin
        do b = 8'($urandom_range(255));
        while (itp_tb_pkg::alpha_char(b) || b == itp_pkg::CH_LPAREN ||
               b == itp_pkg::CH_RPAREN);
        return b;
      end
    endcase
  endfunction

  // Well-formed expression with random nesting
  task automatic build_expression();
    int operands;
    int open;
    operands = $urandom_range(1, 8);
    open = 0;
    infix_text.delete();
    for (int k = 0; k < operands; k++) begin
      while (open < 5 && $urandom_range(3) == 0) begin
        infix_text.push_back(itp_pkg::CH_LPAREN);
        open++;
      end
      infix_text.push_back(rand_letter());
      while (open > 0 && $urandom_range(2) == 0) begin
        infix_text.push_back(itp_pkg::CH_RPAREN);
        open--;
      end
      if (k < operands - 1) infix_text.push_back(rand_op());
    end
    while (open > 0) begin
      infix_text.push_back(itp_pkg::CH_RPAREN);
      open--;
    end
  endtask

  // Deep nesting, running past the stack depth at times
  task automatic build_deep();
    int depth;
    int closes;
    depth  = $urandom_range(itp_pkg::STACK_DEPTH - 4, itp_pkg::STACK_DEPTH + 4);
    closes = $urandom_range(depth - 4, depth + 2);
    infix_text.delete();
    for (int i = 0; i < depth; i++) infix_text.push_back(itp_pkg::CH_LPAREN);
    infix_text.push_back(rand_letter());
    infix_text.push_back(rand_op());
    infix_text.push_back(rand_letter());
    for (int i = 0; i < closes; i++) infix_text.push_back(itp_pkg::CH_RPAREN);
  endtask

  // Random mix of letters, operators and brackets
  task automatic build_broken();
    int len;
    len = $urandom_range(1, 10);
    infix_text.delete();
    repeat (len) begin
      case ($urandom_range(3))
        0:       infix_text.push_back(rand_letter());
        1:       infix_text.push_back(rand_op());
        2:       infix_text.push_back(itp_pkg::CH_LPAREN);
        default: infix_text.push_back(itp_pkg::CH_RPAREN);
      endcase
    end
  endtask

  // Any byte, last flag at random
  task automatic send_noise();
    repeat ($urandom_range(1, 6))
      send_char(8'($urandom_range(255)), $urandom_range(7) == 0);
  endtask

  // One phase of random words
  task automatic run_phase(input int unsigned idle, input int unsigned stall,
                           input bit deep_first);
    int unsigned start;
    int unsigned pick;
    idle_pct  = idle;
    stall_pct = stall;
    start     = words_sent;
    if (deep_first) begin
      build_deep();
      send_text();
    end
    while (words_sent - start < PHASE_WORDS) begin
      pick = $urandom_range(99);
      if (pick < 55) begin
        build_expression();
        send_text();
      end else if (pick < 62) begin
        build_deep();
        send_text();
      end else if (pick < 82) begin
        build_broken();
        send_text();
      end else begin
        send_noise();
      end
    end
    drain();
  endtask

  // Main sequence
  initial begin
    sb           = new();
    words_sent   = 0;
    idle_pct     = 0;
    stall_pct    = 0;
    quiet_cycles = 0;
    rst          = 1'b1;
    in_if.valid  = 1'b0;
    in_if.data   = '0;
    out_if.ready = 1'b0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: letter extremes, all operators with chained '^'
    send_string("A");
    send_string("z");
    send_string("a+b*c^d^e/f-Z");
    // unmatched ')', empty result, odd bytes, leftover '('
    send_char(itp_pkg::CH_RPAREN, 1'b1);
    send_char(itp_pkg::CH_LPAREN, 1'b0);
    send_char(itp_pkg::CH_RPAREN, 1'b1);
    send_char(8'h00, 1'b1);
    send_char(8'hFF, 1'b1);
    send_char(itp_pkg::CH_LPAREN, 1'b0);
    send_char(itp_pkg::CH_LPAREN, 1'b1);
    drain();

    run_phase(0, 0, 1'b1);
    run_phase(52, 0, 1'b0);
    run_phase(0, 52, 1'b0);
    run_phase(12, 12, 1'b1);

    if (sb.pending() != 0)
      sb.report($sformatf("%0d postfix words never arrived", sb.pending()));
    if (sb.mismatches == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

### files.f
design/itp_pkg.sv
design/itp_in_if.sv
design/itp_out_if.sv
design/infix_to_postfix_converter.sv
bench/itp_tb_pkg.sv
bench/tb_top.sv
